FILE: rtl/core/unsigned_divide_by_invariant_top_assert.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the divide-by-invariant core
// ---------------------------------------------------------------------------
`ifndef UNSIGNED_DIVIDE_BY_INVARIANT_TOP_ASSERT_SVH
`define UNSIGNED_DIVIDE_BY_INVARIANT_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define UDBI_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udbi assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define UDBI_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udbi assertion failed");

`endif

FILE: rtl/core/udbi_pkg.sv
// ---------------------------------------------------------------------------
// udbi_pkg
// shared types and constants of the divide-by-invariant core
// ---------------------------------------------------------------------------
package udbi_pkg;

    localparam int WORD_W   = 32;
    localparam int SHIFT_W  = 6;
    localparam int P_W      = 7;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 72;

    localparam logic [WORD_W-1:0]  TOP_BIT      = 32'h8000_0000;
    localparam logic [WORD_W-1:0]  TOP_LESS_ONE = 32'h7FFF_FFFF;
    localparam logic [P_W-1:0]     P_START      = 7'd31;
    localparam logic [P_W-1:0]     P_LIMIT      = 7'd64;
    localparam logic [P_W-1:0]     P_WORD       = 7'd32;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX    = 6'd32;

    // derived constants for one divisor
    typedef struct packed {
        logic [WORD_W-1:0]  multiplier;
        logic [SHIFT_W-1:0] shift;
        logic               add;
        logic               div_one;
    } magic_t;

    // request to the serial divider
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } div_req_t;

    // answer from the serial divider
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] rem;
    } div_rsp_t;

endpackage

FILE: rtl/core/udbi_divider.sv
// ---------------------------------------------------------------------------
// udbi_divider
// restoring radix-2 divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module udbi_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  udbi_pkg::div_req_t req,
    output udbi_pkg::div_rsp_t rsp
);
    import udbi_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [4:0]          cnt_reg;
    logic [WORD_W-1:0]   rem_reg;
    logic [WORD_W-1:0]   num_reg;
    logic [WORD_W-1:0]   den_reg;

    logic [WORD_W:0]     trial;
    logic [WORD_W:0]     diff;
    logic                ge;

    assign trial = {rem_reg, num_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in behind the dividend bits
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            num_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            num_reg <= {num_reg[WORD_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;
    assign rsp.rem  = rem_reg;

`include "unsigned_divide_by_invariant_top_assert.svh"

    `UDBI_ASSERT_IMP(a_start_when_free, req.start, !busy_reg)
    `UDBI_ASSERT_IMP(a_rem_below_den, done_reg, rem_reg < den_reg)

endmodule

FILE: rtl/core/udbi_magic.sv
// ---------------------------------------------------------------------------
// udbi_magic
// magic-number search run after each non-zero divisor write taken while idle
// ---------------------------------------------------------------------------
module udbi_magic (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [udbi_pkg::WORD_W-1:0] cfg_wdata,
    output logic                       busy,
    output udbi_pkg::magic_t           magic,
    output udbi_pkg::div_req_t         div_req,
    input  udbi_pkg::div_rsp_t         div_rsp
);
    import udbi_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DIV_REM = 6'b000010,
        ST_DIV_A   = 6'b000100,
        ST_DIV_B   = 6'b001000,
        ST_STEP    = 6'b010000,
        ST_TEST    = 6'b100000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    magic_t              magic_reg;
    logic                start_reg;
    logic [WORD_W-1:0]   num_reg;
    logic [WORD_W-1:0]   den_reg;

    logic [WORD_W-1:0]   d_reg;
    logic [WORD_W-1:0]   limit_reg;
    logic [WORD_W-1:0]   qa_reg;
    logic [WORD_W-1:0]   ra_reg;
    logic [WORD_W-1:0]   qb_reg;
    logic [WORD_W-1:0]   rb_reg;
    logic [P_W-1:0]      p_reg;
    logic                flag_reg;

    logic                cfg_take;
    logic                ra_br;
    logic                rb_br;
    logic [WORD_W-1:0]   qa_next;
    logic [WORD_W-1:0]   ra_next;
    logic [WORD_W-1:0]   qb_next;
    logic [WORD_W-1:0]   rb_next;
    logic                flag_set;
    logic [WORD_W-1:0]   gap;
    logic                keep_going;

    assign cfg_take = cfg_we && (cfg_wdata != '0);

    // one doubling round of both running quotients
    always_comb
    begin
        ra_br    = (ra_reg >= (limit_reg - ra_reg));
        qa_next  = {qa_reg[WORD_W-2:0], ra_br};
        ra_next  = ra_br ? ((ra_reg << 1) - limit_reg) : (ra_reg << 1);
        rb_br    = ((rb_reg + 32'd1) >= (d_reg - rb_reg));
        qb_next  = {qb_reg[WORD_W-2:0], rb_br};
        rb_next  = rb_br ? ((rb_reg << 1) + 32'd1 - d_reg) : ((rb_reg << 1) + 32'd1);
        flag_set = rb_br ? (qb_reg >= TOP_LESS_ONE) : (qb_reg >= TOP_BIT);
    end

    assign gap        = d_reg - 32'd1 - rb_reg;
    assign keep_going = (p_reg < P_LIMIT) &&
                        ((qa_reg < gap) || ((qa_reg == gap) && (ra_reg == '0)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (cfg_take) state_next = ST_DIV_REM;
            ST_DIV_REM:
                if (div_rsp.done) state_next = ST_DIV_A;
            ST_DIV_A:
                if (div_rsp.done) state_next = ST_DIV_B;
            ST_DIV_B:
                if (div_rsp.done) state_next = ST_STEP;
            ST_STEP:
                state_next = ST_TEST;
            ST_TEST:
                state_next = keep_going ? ST_STEP : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            start_reg            <= 1'b0;
            magic_reg.multiplier <= 32'd2;
            magic_reg.shift      <= '0;
            magic_reg.add        <= 1'b1;
            magic_reg.div_one    <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= ((state_reg == ST_IDLE) && cfg_take) ||
                         (((state_reg == ST_DIV_REM) || (state_reg == ST_DIV_A)) &&
                          div_rsp.done);
            if ((state_reg == ST_TEST) && !keep_going)
            begin
                magic_reg.multiplier <= qb_reg + 32'd1;
                magic_reg.shift      <= SHIFT_W'(p_reg - P_WORD);
                magic_reg.add        <= flag_reg;
                magic_reg.div_one    <= (d_reg == 32'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (cfg_take)
                begin
                    d_reg   <= cfg_wdata;
                    num_reg <= 32'd0 - cfg_wdata;
                    den_reg <= cfg_wdata;
                end
            ST_DIV_REM:
                if (div_rsp.done)
                begin
                    // limit = all ones minus (2^32 mod d)
                    limit_reg <= ~div_rsp.rem;
                    num_reg   <= TOP_BIT;
                    den_reg   <= ~div_rsp.rem;
                end
            ST_DIV_A:
                if (div_rsp.done)
                begin
                    qa_reg  <= div_rsp.quo;
                    ra_reg  <= div_rsp.rem;
                    num_reg <= TOP_BIT;
                    den_reg <= d_reg;
                end
            ST_DIV_B:
                if (div_rsp.done)
                begin
                    qb_reg   <= div_rsp.quo;
                    rb_reg   <= div_rsp.rem;
                    p_reg    <= P_START;
                    flag_reg <= 1'b0;
                end
            ST_STEP:
            begin
                qa_reg <= qa_next;
                ra_reg <= ra_next;
                qb_reg <= qb_next;
                rb_reg <= rb_next;
                p_reg  <= p_reg + 7'd1;
                if (flag_set) flag_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign magic         = magic_reg;
    assign div_req.start = start_reg;
    assign div_req.num   = num_reg;
    assign div_req.den   = den_reg;

`include "unsigned_divide_by_invariant_top_assert.svh"

    `UDBI_ASSERT_IMP(a_done_in_div_state, div_rsp.done,
        (state_reg == ST_DIV_REM) || (state_reg == ST_DIV_A) || (state_reg == ST_DIV_B))
    `UDBI_ASSERT_IMP(a_round_bound, state_reg == ST_TEST, p_reg <= P_LIMIT)
    `UDBI_ASSERT_NXT(a_shift_bound, (state_reg == ST_TEST) && !keep_going,
        magic_reg.shift <= SHIFT_MAX)

endmodule

FILE: rtl/core/udbi_datapath.sv
// ---------------------------------------------------------------------------
// udbi_datapath
// input register, multiply-high register, shift/correct into result register
// ---------------------------------------------------------------------------
module udbi_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        hold,
    input  udbi_pkg::magic_t            magic,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [udbi_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [udbi_pkg::OUT_W-1:0]  m_axis_tdata
);
    import udbi_pkg::*;

    logic                a_valid_reg;
    logic [WORD_W-1:0]   a_x_reg;
    logic                b_valid_reg;
    logic [WORD_W-1:0]   b_x_reg;
    logic [WORD_W-1:0]   b_hi_reg;
    logic                o_valid_reg;
    logic [OUT_W-1:0]    o_data_reg;

    logic                o_ready;
    logic                b_ready;
    logic                a_ready;
    logic [2*WORD_W-1:0] product;
    logic [SHIFT_W-1:0]  sh_clip;
    logic [SHIFT_W-1:0]  sh_less;
    logic [WORD_W-1:0]   diff;
    logic [WORD_W:0]     t_sum;
    logic [WORD_W:0]     t_shift;
    logic [WORD_W-1:0]   quotient;

    assign o_ready = !o_valid_reg || m_axis_tready;
    assign b_ready = !b_valid_reg || o_ready;
    assign a_ready = !a_valid_reg || b_ready;

    assign s_axis_tready = a_ready && !hold;

    assign product = {32'd0, a_x_reg} * {32'd0, magic.multiplier};

    always_comb
    begin
        sh_clip  = (magic.shift > SHIFT_MAX) ? SHIFT_MAX : magic.shift;
        sh_less  = (sh_clip == '0) ? '0 : (sh_clip - 6'd1);
        diff     = b_x_reg - b_hi_reg;
        // add-and-halve path keeps the carry bit
        t_sum    = {2'b00, diff[WORD_W-1:1]} + {1'b0, b_hi_reg};
        t_shift  = t_sum >> sh_less;
        if (magic.div_one)
            quotient = b_x_reg;
        else if (magic.add)
            quotient = t_shift[WORD_W-1:0];
        else
            quotient = b_hi_reg >> sh_clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready) a_valid_reg <= s_axis_tvalid && s_axis_tready;
            if (b_ready) b_valid_reg <= a_valid_reg;
            if (o_ready) o_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready) a_x_reg <= s_axis_tdata;
        if (b_ready)
        begin
            b_x_reg  <= a_x_reg;
            b_hi_reg <= product[2*WORD_W-1:WORD_W];
        end
        if (o_ready)
            o_data_reg <= {1'b0, magic.add, magic.shift, magic.multiplier, quotient};
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = o_data_reg;

endmodule

FILE: rtl/core/unsigned_divide_by_invariant_top.sv
// ---------------------------------------------------------------------------
// unsigned_divide_by_invariant_top
// unsigned 32-bit divide by a configured divisor through a magic multiplier
// ---------------------------------------------------------------------------
//   port group   dir   bits  contents
//   cfg          in    32    divisor write (zero is ignored)
//   s_axis       in    32    dividend
//   m_axis       out   72    quotient, multiplier, post shift, add flag
//
// one dividend per cycle when neither m_axis nor a magic search stalls
// a divisor write starts the magic search: three serial divides, then 1 to
// 33 rounds, each an ST_STEP and an ST_TEST state; s_axis_tready stays low
// meanwhile
// reset loads the constants for a divisor of one, no search needed
// a stalled result holds in the output register while the pipe fills behind it
// ---------------------------------------------------------------------------
module unsigned_divide_by_invariant_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [udbi_pkg::WORD_W-1:0] cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [31:0] dividend
    input  logic [udbi_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [31:0] quotient, [63:32] magic_multiplier, [69:64] post_shift,
    // [70] add_flag, [71] zero
    output logic [udbi_pkg::OUT_W-1:0]  m_axis_tdata
);
    import udbi_pkg::*;

    magic_t   magic;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     busy;
    logic     hold;

    assign hold = busy || cfg_we;

    udbi_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    udbi_magic u_magic (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .busy      (busy),
        .magic     (magic),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    udbi_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .hold          (hold),
        .magic         (magic),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
